>>> hw/rtl/bkh_pkg.sv
// shared types, constants and microcode word format for the k-smallest heap
`timescale 1ns / 1ps

package bkh_pkg;

    // sizing
    localparam int CAPACITY    = 16;
    localparam int MAX_RESULTS = 16;
    localparam int VAL_W       = 32;
    localparam int CNT_W       = 5;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int KEEP_RESET  = 16;
    localparam int KMAX        = (CAPACITY < 31) ? CAPACITY : 31;
    localparam int DUMP_MAX    = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;
    localparam int POS_W       = (IDX_W + 2 > CNT_W) ? IDX_W + 2 : CNT_W;
    localparam int PC_W        = 5;

    // register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_KEEP = '0;

    // item kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_DUMP = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic signed [VAL_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic                    accepted;
        logic [CNT_W-1:0]        held_count;
        logic                    is_full;
        logic                    item_valid;
        logic                    last_of_run;
    } t_out_beat;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_REPL_INIT,
        OP_STORE,
        OP_BUILD_INIT,
        OP_RD_CHILD,
        OP_CMP,
        OP_WR_CUR,
        OP_PAR_DEC,
        OP_LD_CUR,
        OP_EMIT_PUSH,
        OP_DUMP_INIT,
        OP_DUMP_RD,
        OP_DUMP_EMIT,
        OP_EMIT_EMPTY
    } t_op;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NOACC,
        C_DUMP,
        C_NOTFULL,
        C_GE_ROOT,
        C_NOCHILD,
        C_CHILD_GT,
        C_PAR_ZERO,
        C_EMPTY,
        C_NOTLAST
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic            wait_out;
        logic [PC_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic in_acc;
        logic is_dump;
        logic not_full;
        logic ge_root;
        logic no_child;
        logic child_gt;
        logic par_zero;
        logic empty;
        logic not_last;
        logic out_busy;
    } t_flags;

endpackage

>>> hw/rtl/bounded_max_heap_k_smallest.sv
// top level: keeps the k smallest values of a stream in a ram-based max-heap
`timescale 1ns / 1ps
// a push while filling appends to the store; a push not below the root is discarded
// otherwise it replaces the root and sifts down; each level reads both children and compares
// the push that fills the store builds the heap once, sifting down each parent from the last
// a dump emits the held values in store order, or one empty beat when the store is empty
// a finished beat may wait while the next item enters; a stalled output holds the sequencer at its next emit step
// reset empties the store (count 0) and sets keep_count to 16; the ram is not cleared

module bounded_max_heap_k_smallest (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bkh_pkg::t_in_beat            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bkh_pkg::t_out_beat           o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bkh_pkg::PADDR_W-1:0]  paddr,
    input  logic [bkh_pkg::PDATA_W-1:0]  pwdata,
    output logic [bkh_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    bkh_pkg::t_ctrl  w_ctrl;
    bkh_pkg::t_flags w_flags;

    // program sequencer
    bkh_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    // heap datapath
    bkh_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_flags     (w_flags),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

endmodule

>>> hw/rtl/bkh_ram.sv
// generic single-write, dual-read ram with registered read data
`timescale 1ns / 1ps

module bkh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> hw/rtl/bkh_seq.sv
// microcode sequencer: program rom, step counter and conditional jumps
`timescale 1ns / 1ps

module bkh_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bkh_pkg::t_flags i_flags,
    output bkh_pkg::t_ctrl  o_ctrl
);

    // program labels
    localparam logic [bkh_pkg::PC_W-1:0] L_FETCH = bkh_pkg::PC_W'(0);
    localparam logic [bkh_pkg::PC_W-1:0] L_STORE = bkh_pkg::PC_W'(5);
    localparam logic [bkh_pkg::PC_W-1:0] L_SIFT  = bkh_pkg::PC_W'(8);
    localparam logic [bkh_pkg::PC_W-1:0] L_SEND  = bkh_pkg::PC_W'(10);
    localparam logic [bkh_pkg::PC_W-1:0] L_AFTER = bkh_pkg::PC_W'(11);
    localparam logic [bkh_pkg::PC_W-1:0] L_EMITP = bkh_pkg::PC_W'(14);
    localparam logic [bkh_pkg::PC_W-1:0] L_DUMP  = bkh_pkg::PC_W'(15);
    localparam logic [bkh_pkg::PC_W-1:0] L_DRD   = bkh_pkg::PC_W'(16);
    localparam logic [bkh_pkg::PC_W-1:0] L_DEMPT = bkh_pkg::PC_W'(19);

    logic [bkh_pkg::PC_W-1:0] r_pc;
    logic [bkh_pkg::PC_W-1:0] n_pc;
    bkh_pkg::t_ctrl           w_word;
    logic                     w_take;

    function automatic bkh_pkg::t_ctrl mk(input bkh_pkg::t_op op, input bkh_pkg::t_cond cond,
                                          input logic wait_out,
                                          input logic [bkh_pkg::PC_W-1:0] target);
        bkh_pkg::t_ctrl w;
        w.op       = op;
        w.cond     = cond;
        w.wait_out = wait_out;
        w.target   = target;
        return w;
    endfunction

    // control store
    function automatic bkh_pkg::t_ctrl rom(input logic [bkh_pkg::PC_W-1:0] pc);
        bkh_pkg::t_ctrl w;
        unique case (pc)
            // wait for an item, then dispatch
            5'd0:  w = mk(bkh_pkg::OP_FETCH,      bkh_pkg::C_NOACC,    1'b0, L_FETCH);
            5'd1:  w = mk(bkh_pkg::OP_NOP,        bkh_pkg::C_DUMP,     1'b0, L_DUMP);
            5'd2:  w = mk(bkh_pkg::OP_NOP,        bkh_pkg::C_NOTFULL,  1'b0, L_STORE);
            5'd3:  w = mk(bkh_pkg::OP_NOP,        bkh_pkg::C_GE_ROOT,  1'b0, L_EMITP);
            5'd4:  w = mk(bkh_pkg::OP_REPL_INIT,  bkh_pkg::C_ALWAYS,   1'b0, L_SIFT);
            // append while filling, build heap on the last one
            5'd5:  w = mk(bkh_pkg::OP_STORE,      bkh_pkg::C_NEXT,     1'b0, L_FETCH);
            5'd6:  w = mk(bkh_pkg::OP_NOP,        bkh_pkg::C_NOTFULL,  1'b0, L_EMITP);
            5'd7:  w = mk(bkh_pkg::OP_BUILD_INIT, bkh_pkg::C_ALWAYS,   1'b0, L_AFTER);
            // sift-down loop, one level per pass
            5'd8:  w = mk(bkh_pkg::OP_RD_CHILD,   bkh_pkg::C_NOCHILD,  1'b0, L_SEND);
            5'd9:  w = mk(bkh_pkg::OP_CMP,        bkh_pkg::C_CHILD_GT, 1'b0, L_SIFT);
            5'd10: w = mk(bkh_pkg::OP_WR_CUR,     bkh_pkg::C_NEXT,     1'b0, L_FETCH);
            // next parent of the build, or done
            5'd11: w = mk(bkh_pkg::OP_NOP,        bkh_pkg::C_PAR_ZERO, 1'b0, L_EMITP);
            5'd12: w = mk(bkh_pkg::OP_PAR_DEC,    bkh_pkg::C_NEXT,     1'b0, L_FETCH);
            5'd13: w = mk(bkh_pkg::OP_LD_CUR,     bkh_pkg::C_ALWAYS,   1'b0, L_SIFT);
            5'd14: w = mk(bkh_pkg::OP_EMIT_PUSH,  bkh_pkg::C_ALWAYS,   1'b1, L_FETCH);
            // dump in store order
            5'd15: w = mk(bkh_pkg::OP_DUMP_INIT,  bkh_pkg::C_EMPTY,    1'b0, L_DEMPT);
            5'd16: w = mk(bkh_pkg::OP_DUMP_RD,    bkh_pkg::C_NEXT,     1'b0, L_FETCH);
            5'd17: w = mk(bkh_pkg::OP_DUMP_EMIT,  bkh_pkg::C_NOTLAST,  1'b1, L_DRD);
            5'd18: w = mk(bkh_pkg::OP_NOP,        bkh_pkg::C_ALWAYS,   1'b0, L_FETCH);
            5'd19: w = mk(bkh_pkg::OP_EMIT_EMPTY, bkh_pkg::C_ALWAYS,   1'b1, L_FETCH);
            default: w = mk(bkh_pkg::OP_NOP,      bkh_pkg::C_ALWAYS,   1'b0, L_FETCH);
        endcase
        return w;
    endfunction

    assign w_word = rom(r_pc);
    assign o_ctrl = w_word;

    // condition select
    always_comb begin
        unique case (w_word.cond)
            bkh_pkg::C_NEXT:     w_take = 1'b0;
            bkh_pkg::C_ALWAYS:   w_take = 1'b1;
            bkh_pkg::C_NOACC:    w_take = !i_flags.in_acc;
            bkh_pkg::C_DUMP:     w_take = i_flags.is_dump;
            bkh_pkg::C_NOTFULL:  w_take = i_flags.not_full;
            bkh_pkg::C_GE_ROOT:  w_take = i_flags.ge_root;
            bkh_pkg::C_NOCHILD:  w_take = i_flags.no_child;
            bkh_pkg::C_CHILD_GT: w_take = i_flags.child_gt;
            bkh_pkg::C_PAR_ZERO: w_take = i_flags.par_zero;
            bkh_pkg::C_EMPTY:    w_take = i_flags.empty;
            bkh_pkg::C_NOTLAST:  w_take = i_flags.not_last;
            default:             w_take = 1'b0;
        endcase
    end

    // next step: hold an emit step while the output beat cannot leave
    always_comb begin
        if (w_word.wait_out && i_flags.out_busy) begin
            n_pc = r_pc;
        end else if (w_take) begin
            n_pc = w_word.target;
        end else begin
            n_pc = r_pc + bkh_pkg::PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= L_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> hw/rtl/bkh_dp.sv
// heap datapath: store ram, sift registers, counters, register port, output beat
`timescale 1ns / 1ps

module bkh_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bkh_pkg::t_ctrl                i_ctrl,
    output bkh_pkg::t_flags               o_flags,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bkh_pkg::t_in_beat             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bkh_pkg::t_out_beat            o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bkh_pkg::PADDR_W-1:0]   paddr,
    input  logic [bkh_pkg::PDATA_W-1:0]   pwdata,
    output logic [bkh_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int IW = bkh_pkg::IDX_W;
    localparam int CW = bkh_pkg::CNT_W;
    localparam int PW = bkh_pkg::POS_W;
    localparam int VW = bkh_pkg::VAL_W;

    bkh_pkg::t_in_beat  r_in;
    bkh_pkg::t_out_beat r_out;
    bkh_pkg::t_out_beat w_beat;
    logic               r_out_valid;
    logic [CW-1:0]      r_keep;
    logic [CW-1:0]      r_held;
    logic [CW-1:0]      r_par;
    logic [CW-1:0]      r_dptr;
    logic [IW-1:0]      r_idx;
    logic signed [VW-1:0] r_cur;
    logic signed [VW-1:0] r_root;
    logic               r_acc;

    logic [CW-1:0]      w_keff;
    logic [CW-1:0]      w_ndump;
    logic [PW-1:0]      w_pos_l;
    logic [PW-1:0]      w_pos_r;
    logic [PW-1:0]      w_npos;
    logic               w_r_ok;
    logic               w_take_r;
    logic signed [VW-1:0] w_rd_a;
    logic signed [VW-1:0] w_rd_b;
    logic [VW-1:0]      w_ram_a;
    logic [VW-1:0]      w_ram_b;
    logic signed [VW-1:0] w_child_val;
    logic [IW-1:0]      w_child_idx;
    logic               w_child_gt;
    logic [IW-1:0]      w_raddr_a;
    logic [IW-1:0]      w_raddr_b;
    logic               w_we;
    logic [IW-1:0]      w_waddr;
    logic signed [VW-1:0] w_wdata;
    logic               w_full;
    logic               w_busy;
    logic               w_emit;
    logic               w_accept;
    logic               w_cfg_wr;
    logic               w_reg_hit;

    // effective keep count, clamped to 1..capacity
    always_comb begin
        if (r_keep == '0) begin
            w_keff = CW'(1);
        end else if (r_keep > CW'(bkh_pkg::KMAX)) begin
            w_keff = CW'(bkh_pkg::KMAX);
        end else begin
            w_keff = r_keep;
        end
    end

    assign w_ndump = (r_held > CW'(bkh_pkg::DUMP_MAX)) ? CW'(bkh_pkg::DUMP_MAX) : r_held;
    assign w_full  = (r_held == w_keff);

    // child positions of the current node
    assign w_pos_l = (PW'(r_idx) << 1) + PW'(1);
    assign w_pos_r = w_pos_l + PW'(1);
    assign w_npos  = PW'(w_keff);
    assign w_r_ok  = (w_pos_r < w_npos);

    // larger child, ties go right
    assign w_rd_a      = $signed(w_ram_a);
    assign w_rd_b      = $signed(w_ram_b);
    assign w_take_r    = w_r_ok && (w_rd_b >= w_rd_a);
    assign w_child_val = w_take_r ? w_rd_b : w_rd_a;
    assign w_child_idx = w_take_r ? IW'(w_pos_r) : IW'(w_pos_l);
    assign w_child_gt  = (w_child_val > r_cur);

    // handshakes
    assign w_busy     = r_out_valid && !i_out_ready;
    assign o_in_ready = (i_ctrl.op == bkh_pkg::OP_FETCH);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_reg_hit  = (paddr[bkh_pkg::PADDR_W-1:2] == bkh_pkg::REG_KEEP);
    assign w_cfg_wr   = psel && penable && pwrite && w_reg_hit;
    assign pready     = 1'b1;
    assign prdata     = w_reg_hit ? bkh_pkg::PDATA_W'(r_keep) : '0;

    // ram read addresses
    always_comb begin
        w_raddr_a = '0;
        w_raddr_b = '0;
        unique case (i_ctrl.op)
            bkh_pkg::OP_RD_CHILD, bkh_pkg::OP_CMP: begin
                w_raddr_a = IW'(w_pos_l);
                w_raddr_b = IW'(w_pos_r);
            end
            bkh_pkg::OP_PAR_DEC: begin
                w_raddr_a = IW'(r_par - CW'(1));
            end
            bkh_pkg::OP_DUMP_RD, bkh_pkg::OP_DUMP_EMIT: begin
                w_raddr_a = IW'(r_dptr);
            end
            default: begin
                w_raddr_a = '0;
            end
        endcase
    end

    // ram write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_cur;
        unique case (i_ctrl.op)
            bkh_pkg::OP_STORE: begin
                w_we    = 1'b1;
                w_waddr = IW'(r_held);
                w_wdata = r_in.value;
            end
            bkh_pkg::OP_CMP: begin
                w_we    = w_child_gt;
                w_wdata = w_child_val;
            end
            bkh_pkg::OP_WR_CUR: begin
                w_we    = 1'b1;
            end
            default: begin
                w_we    = 1'b0;
            end
        endcase
    end

    bkh_ram #(
        .WIDTH (VW),
        .DEPTH (bkh_pkg::CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_ram_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_ram_b)
    );

    // output beat contents
    always_comb begin
        w_emit              = 1'b0;
        w_beat.result_value = '0;
        w_beat.accepted     = 1'b0;
        w_beat.held_count   = r_held;
        w_beat.is_full      = w_full;
        w_beat.item_valid   = 1'b1;
        w_beat.last_of_run  = 1'b1;
        unique case (i_ctrl.op)
            bkh_pkg::OP_EMIT_PUSH: begin
                w_emit              = !w_busy;
                w_beat.result_value = w_full ? r_root : '0;
                w_beat.accepted     = r_acc;
            end
            bkh_pkg::OP_DUMP_EMIT: begin
                w_emit              = !w_busy;
                w_beat.result_value = w_rd_a;
                w_beat.last_of_run  = ((r_dptr + CW'(1)) == w_ndump);
            end
            bkh_pkg::OP_EMIT_EMPTY: begin
                w_emit              = !w_busy;
                w_beat.held_count   = '0;
                w_beat.is_full      = 1'b0;
                w_beat.item_valid   = 1'b0;
            end
            default: begin
                w_emit              = 1'b0;
            end
        endcase
    end

    // status for the sequencer
    assign o_flags.in_acc   = w_accept;
    assign o_flags.is_dump  = (r_in.kind == bkh_pkg::KIND_DUMP);
    assign o_flags.not_full = !w_full;
    assign o_flags.ge_root  = (r_in.value >= r_root);
    assign o_flags.no_child = (w_pos_l >= w_npos);
    assign o_flags.child_gt = w_child_gt;
    assign o_flags.par_zero = (r_par == '0);
    assign o_flags.empty    = (r_held == '0);
    assign o_flags.not_last = ((r_dptr + CW'(1)) != w_ndump);
    assign o_flags.out_busy = w_busy;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep      <= CW'(bkh_pkg::KEEP_RESET);
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_keep <= pwdata[CW-1:0];
                r_held <= '0;
            end else if (i_ctrl.op == bkh_pkg::OP_STORE) begin
                r_held <= r_held + CW'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers and output beat
    always_ff @(posedge i_clk) begin
        if (w_we && (w_waddr == '0)) begin
            r_root <= w_wdata;
        end
        if (w_emit) begin
            r_out <= w_beat;
        end
        unique case (i_ctrl.op)
            bkh_pkg::OP_FETCH: begin
                if (w_accept) begin
                    r_in  <= i_in_data;
                    r_acc <= 1'b0;
                end
            end
            bkh_pkg::OP_REPL_INIT: begin
                r_cur <= r_in.value;
                r_idx <= '0;
                r_par <= '0;
                r_acc <= 1'b1;
            end
            bkh_pkg::OP_STORE: begin
                r_acc <= 1'b1;
            end
            bkh_pkg::OP_BUILD_INIT: begin
                r_par <= w_keff >> 1;
            end
            bkh_pkg::OP_CMP: begin
                if (w_child_gt) begin
                    r_idx <= w_child_idx;
                end
            end
            bkh_pkg::OP_PAR_DEC: begin
                r_par <= r_par - CW'(1);
            end
            bkh_pkg::OP_LD_CUR: begin
                r_cur <= w_rd_a;
                r_idx <= IW'(r_par);
            end
            bkh_pkg::OP_DUMP_INIT: begin
                r_dptr <= '0;
            end
            bkh_pkg::OP_DUMP_EMIT: begin
                if (w_emit) begin
                    r_dptr <= r_dptr + CW'(1);
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
